/* rtl/cbc_pkg.sv */
// Shared types, codes and reset values of the cartridge bank controller.
package cbc_pkg;

	localparam int ADDR_W     = 16;
	localparam int BYTE_W     = 8;
	localparam int ROM_ADDR_W = 23;
	localparam int RAM_ADDR_W = 17;
	localparam int KIND_W     = 3;
	localparam int TGT_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 23;
	localparam int S_DATA_W   = 24;
	localparam int M_DATA_W   = 32;

	localparam logic [KIND_W-1:0] KIND_NONE = 3'd0;
	localparam logic [KIND_W-1:0] KIND_MBC1 = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MBC2 = 3'd2;
	localparam logic [KIND_W-1:0] KIND_MBC3 = 3'd3;
	localparam logic [KIND_W-1:0] KIND_MBC5 = 3'd4;

	localparam logic [TGT_W-1:0] TGT_CTRL_WR = 3'd0;
	localparam logic [TGT_W-1:0] TGT_ROM_RD  = 3'd1;
	localparam logic [TGT_W-1:0] TGT_RAM_RD  = 3'd2;
	localparam logic [TGT_W-1:0] TGT_RAM_WR  = 3'd3;
	localparam logic [TGT_W-1:0] TGT_ZERO_RD = 3'd4;
	localparam logic [TGT_W-1:0] TGT_CLK_RD  = 3'd5;
	localparam logic [TGT_W-1:0] TGT_DROP_WR = 3'd6;

	localparam logic [CFG_IDX_W-1:0] CFG_CART_KIND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROM_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_LIMIT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_EN  = 2'd3;

	localparam logic [ROM_ADDR_W-1:0] ROM_LIMIT_RESET = 23'h007fff;
	localparam logic [BYTE_W-1:0]     CLK_BANK_MAX    = 8'd7;

	typedef struct packed {
		logic [BYTE_W-1:0] bank_low;
		logic [BYTE_W-1:0] bank_high;
		logic [BYTE_W-1:0] ram_page;
		logic              ram_en;
		logic              bank_mode;
	} bank_state_t;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [ROM_ADDR_W-1:0] rom_limit;
		logic [RAM_ADDR_W-1:0] ram_limit;
		logic                  clock_en;
	} cart_cfg_t;

endpackage

/* rtl/cbc_bank_regs.sv */
// Configuration registers and bank state with the per-kind control write decode.
module cbc_bank_regs import cbc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  ctrl_we,
	input  logic [ADDR_W-1:0]     ctrl_address,
	input  logic [BYTE_W-1:0]     ctrl_data,
	output cart_cfg_t             cfg,
	output bank_state_t           bank
);

	cart_cfg_t   cfg_q;
	bank_state_t bank_q;
	bank_state_t bank_nxt;
	logic        en_nibble;
	logic [2:0]  region;
	logic [3:0]  region4k;

	assign en_nibble = (ctrl_data[3:0] == 4'ha);
	assign region    = ctrl_address[15:13];
	assign region4k  = ctrl_address[15:12];

	always_comb begin
		bank_nxt = bank_q;
		unique case (cfg_q.kind)
			KIND_MBC1: begin
				priority case (region)
					3'd0: bank_nxt.ram_en = en_nibble;
					3'd1: begin
						bank_nxt.bank_low = {3'b000, ctrl_data[4:0]};
						if (ctrl_data[4:0] == 5'd0) begin
							bank_nxt.bank_low = 8'd1;
						end
					end
					3'd2: bank_nxt.bank_high = {6'd0, ctrl_data[1:0]};
					3'd3: bank_nxt.bank_mode = ctrl_data[0];
					default: ;
				endcase
			end
			KIND_MBC2: begin
				if (ctrl_address[15:14] == 2'b00) begin
					if (ctrl_address[8]) begin
						bank_nxt.bank_high = {4'd0, ctrl_data[3:0]};
						if (ctrl_data[3:0] == 4'd0) begin
							bank_nxt.bank_high = 8'd1;
						end
					end else begin
						bank_nxt.ram_en = en_nibble;
					end
				end
			end
			KIND_MBC3: begin
				priority case (region)
					3'd0: bank_nxt.ram_en = en_nibble;
					3'd1: begin
						bank_nxt.bank_high = {1'b0, ctrl_data[6:0]};
						if (ctrl_data[6:0] == 7'd0) begin
							bank_nxt.bank_high = 8'd1;
						end
					end
					3'd2: bank_nxt.ram_page = ctrl_data;
					default: ;
				endcase
			end
			KIND_MBC5: begin
				priority if (region == 3'd0) begin
					bank_nxt.ram_en = (ctrl_data == 8'h0a);
				end else if (region4k == 4'h2) begin
					bank_nxt.bank_high = ctrl_data;
				end else if (region4k == 4'h3) begin
					bank_nxt.bank_low = {7'd0, ctrl_data[0]};
				end else if (region == 3'd2) begin
					bank_nxt.ram_page = {4'd0, ctrl_data[3:0]};
				end
			end
			default: begin
				priority case (region)
					3'd0: bank_nxt.ram_en = en_nibble;
					3'd1: bank_nxt.bank_high = ctrl_data;
					3'd2: bank_nxt.ram_page = ctrl_data;
					default: ;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kind       <= KIND_NONE;
			cfg_q.rom_limit  <= ROM_LIMIT_RESET;
			cfg_q.ram_limit  <= '0;
			cfg_q.clock_en   <= 1'b0;
			bank_q.bank_low  <= 8'd0;
			bank_q.bank_high <= 8'd1;
			bank_q.ram_page  <= 8'd0;
			bank_q.ram_en    <= 1'b0;
			bank_q.bank_mode <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CART_KIND: begin
					cfg_q.kind <= cfg_data[KIND_W-1:0];
					if (cfg_data[KIND_W-1:0] == KIND_MBC1) begin
						bank_q.bank_low  <= 8'd1;
						bank_q.bank_high <= 8'd0;
					end else begin
						bank_q.bank_low  <= 8'd0;
						bank_q.bank_high <= 8'd1;
					end
				end
				CFG_ROM_LIMIT: cfg_q.rom_limit <= cfg_data[ROM_ADDR_W-1:0];
				CFG_RAM_LIMIT: cfg_q.ram_limit <= cfg_data[RAM_ADDR_W-1:0];
				CFG_CLOCK_EN:  cfg_q.clock_en <= cfg_data[0];
			endcase
		end else if (ctrl_we) begin
			bank_q <= bank_nxt;
		end
	end

	assign cfg  = cfg_q;
	assign bank = bank_q;

	a_mbc1_low_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_q.kind == KIND_MBC1)
			|-> (bank_q.bank_low != 8'd0 && bank_q.bank_low[7:5] == 3'd0))
		else $error("MBC1 low bank out of range");

	a_mbc23_high_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_q.kind == KIND_MBC2 || cfg_q.kind == KIND_MBC3) |-> (bank_q.bank_high != 8'd0))
		else $error("MBC2/MBC3 ROM bank is zero");

	a_ctrl_only_state: assert property (@(posedge clk) disable iff (!arst_n)
		(!cfg_we && !ctrl_we) |=> ($stable(bank_q) && $stable(cfg_q)))
		else $error("Bank state changed without a write");

endmodule

/* rtl/cbc_translate.sv */
// Access decode and ROM/RAM address translation for one bus access.
module cbc_translate import cbc_pkg::*; (
	input  logic                  mode,
	input  logic [ADDR_W-1:0]     address,
	input  logic [BYTE_W-1:0]     write_data,
	input  cart_cfg_t             cfg,
	input  bank_state_t           bank,
	output logic [TGT_W-1:0]      target,
	output logic [ROM_ADDR_W-1:0] phys_addr,
	output logic [BYTE_W-1:0]     data_out,
	output logic                  ctrl_wr
);

	logic                  low_rom;
	logic                  in_ram;
	logic                  clk_sel;
	logic [8:0]            rom_bank;
	logic [8:0]            high_m1;
	logic [ROM_ADDR_W-1:0] rom_raw;
	logic [RAM_ADDR_W-1:0] ram_raw;

	assign low_rom = (address[15:14] == 2'b00);
	assign in_ram  = (address[15:13] == 3'b101);
	assign clk_sel = cfg.clock_en && (bank.ram_page > CLK_BANK_MAX);
	assign high_m1 = {1'b0, bank.bank_high} - 9'd1;

	always_comb begin
		rom_bank = {1'b0, bank.bank_high};
		rom_raw  = {7'd0, address};
		ram_raw  = {bank.ram_page[3:0], address[12:0]};
		unique case (cfg.kind)
			KIND_MBC1: begin
				rom_bank = bank.bank_mode ? {1'b0, bank.bank_low}
					: ({1'b0, bank.bank_low} | {bank.bank_high[3:0], 5'd0});
				rom_raw  = low_rom ? {7'd0, address} : {rom_bank, address[13:0]};
				ram_raw  = bank.bank_mode ? {bank.bank_high[3:0], address[12:0]}
					: {4'd0, address[12:0]};
			end
			KIND_MBC2: begin
				rom_raw = low_rom ? {7'd0, address} : {rom_bank, address[13:0]};
				ram_raw = {8'd0, address[8:0]};
			end
			KIND_MBC3: begin
				rom_raw = low_rom ? {7'd0, address} : {rom_bank, address[13:0]};
				ram_raw = {2'd0, bank.ram_page[1:0], address[12:0]};
			end
			KIND_MBC5: begin
				rom_bank = {bank.bank_low[0], bank.bank_high};
				rom_raw  = low_rom ? {7'd0, address} : {rom_bank, address[13:0]};
			end
			default: begin
				rom_raw = {7'd0, address} + (low_rom ? {1'b0, bank.bank_low, 14'd0}
					: {high_m1, 14'd0});
			end
		endcase
	end

	always_comb begin
		target    = TGT_CTRL_WR;
		phys_addr = '0;
		data_out  = '0;
		ctrl_wr   = 1'b0;
		priority if (in_ram) begin
			priority if (!bank.ram_en) begin
				target = mode ? TGT_DROP_WR : TGT_ZERO_RD;
			end else if (clk_sel) begin
				if (mode) begin
					target = TGT_DROP_WR;
				end else begin
					target    = TGT_CLK_RD;
					phys_addr = {15'd0, bank.ram_page};
				end
			end else begin
				phys_addr = {6'd0, ram_raw & cfg.ram_limit};
				if (mode) begin
					target   = TGT_RAM_WR;
					data_out = write_data;
				end else begin
					target = TGT_RAM_RD;
				end
			end
		end else if (mode) begin
			target  = TGT_CTRL_WR;
			ctrl_wr = 1'b1;
		end else begin
			target    = TGT_ROM_RD;
			phys_addr = rom_raw & cfg.rom_limit;
		end
	end

endmodule

/* rtl/cartridge_bank_controller.sv */
// Top level of the cartridge bank controller: input stage, result register and glue.
//
// Each word on the slave stream is one cartridge bus access: s_tuser is the
// access kind (read or write), s_tdata carries the bus address and the byte
// written. Each access yields exactly one word on the master stream: m_tuser
// is the target code, m_tdata the translated ROM/RAM byte address (or clock
// register number) and the byte to store for a RAM write.
// An accepted word is held in an input stage, where the access is decoded
// against the current bank state; when the word advances, the result is
// loaded into the output register and a control write updates the bank
// registers, so the following access already sees the new banks.
// One word is accepted in every cycle while results are taken.
// When the receiver stalls, the result stays in the output register and the
// input stage still takes one more word; s_tready then drops until m_tready
// returns. Reset empties both stages and loads the register reset values
// (no controller, ROM mask 0x7FFF, RAM mask zero, no clock).
// Configuration writes through cfg_we are to be issued only while no word is
// in flight.
module cartridge_bank_controller import cbc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,  // address[15:0], write_data[23:16]
	input  logic                  s_tuser,  // mode
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,  // phys_addr[22:0], data_out[30:23], zero[31]
	output logic [TGT_W-1:0]      m_tuser   // target
);

	logic                  valid_s1;
	logic                  mode_s1;
	logic [ADDR_W-1:0]     address_s1;
	logic [BYTE_W-1:0]     wdata_s1;
	logic                  valid_s2;
	logic [TGT_W-1:0]      target_s2;
	logic [ROM_ADDR_W-1:0] phys_s2;
	logic [BYTE_W-1:0]     dout_s2;
	logic                  advance;
	logic                  accept;
	logic [TGT_W-1:0]      target_c;
	logic [ROM_ADDR_W-1:0] phys_c;
	logic [BYTE_W-1:0]     dout_c;
	logic                  ctrl_wr_c;
	cart_cfg_t             cfg;
	bank_state_t           bank;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	cbc_bank_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.ctrl_we      (advance && ctrl_wr_c),
		.ctrl_address (address_s1),
		.ctrl_data    (wdata_s1),
		.cfg          (cfg),
		.bank         (bank)
	);

	cbc_translate u_xlate (
		.mode       (mode_s1),
		.address    (address_s1),
		.write_data (wdata_s1),
		.cfg        (cfg),
		.bank       (bank),
		.target     (target_c),
		.phys_addr  (phys_c),
		.data_out   (dout_c),
		.ctrl_wr    (ctrl_wr_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1    <= s_tuser;
			address_s1 <= s_tdata[ADDR_W-1:0];
			wdata_s1   <= s_tdata[ADDR_W+BYTE_W-1:ADDR_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			target_s2 <= target_c;
			phys_s2   <= phys_c;
			dout_s2   <= dout_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = target_s2;
	assign m_tdata  = {1'b0, dout_s2, phys_s2};

	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && !m_tready))
		else $error("Input stalled while a stage is free");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(address_s1) && $stable(mode_s1)
			&& $stable(wdata_s1)))
		else $error("Input stage lost a pending word");

	a_s2_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("Result register missed a word");

endmodule
